>>> rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the block bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

	// map geometry
	localparam int MAP_SECTORS    = 1;
	localparam int SECTOR_BYTES   = 512;
	localparam int STORE_BYTES    = 512;
	localparam int BYTES_PER_WORD = 4;
	localparam int WORD_W         = 8 * BYTES_PER_WORD;
	localparam int STORE_WORDS    = STORE_BYTES / BYTES_PER_WORD;
	localparam int WADDR_W        = $clog2(STORE_WORDS);
	localparam int MAP_BYTES_RAW  = MAP_SECTORS * SECTOR_BYTES;
	localparam int MAP_BYTES      = (MAP_BYTES_RAW < STORE_BYTES) ? MAP_BYTES_RAW : STORE_BYTES;
	localparam int MAP_WORDS      = (MAP_BYTES + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
	localparam int MAPCMP_W       = 10;

	localparam int BLOCK_W = 12;
	localparam int TDATA_W = 16;

	typedef enum logic [1:0] {
		ACT_TEST    = 2'd0,
		ACT_FIND    = 2'd1,
		ACT_ASSIGN  = 2'd2,
		ACT_RELEASE = 2'd3
	} bba_action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DONE
	} bba_state_t;

	// packs with is_free in the lowest bit
	typedef struct packed {
		logic               found;
		logic [BLOCK_W-1:0] found_block;
		logic               is_free;
	} bba_res_t;

	typedef struct packed {
		logic               re;
		logic [WADDR_W-1:0] raddr;
		logic               we;
		logic [WADDR_W-1:0] waddr;
		logic [WORD_W-1:0]  wdata;
	} bba_ram_req_t;

endpackage

`default_nettype wire

>>> rtl/block_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator_top
// Free-block bitmap: test, find lowest free, assign and release blocks.
// ----------------------------------------------------------------------------
//   channel  dir  fields (tdata, lsb first)
//   s_*      in   action[1:0], block_number[13:2], zero pad to 16
//   m_*      out  is_free[0], found_block[12:1], found[13], zero pad to 16
//
// test, assign and release pass through a ram read, a read-modify-write, a
// result register and an output register.
// find reads one 32-bit word of the bitmap per cycle, up to 128 words for a
// full 512-byte map.
// one request is in flight at a time; a new one is taken while the last
// result still waits on m_tready. reset marks every word as never written,
// which reads as all blocks free, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator_top
	import bba_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,  // action, block_number
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [TDATA_W-1:0] m_tdata   // is_free, found_block, found
);

	bba_ram_req_t      ram_req;
	logic [WORD_W-1:0] ram_rdata;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	bba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STORE_WORDS)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

>>> rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: read-modify-write of bitmap words and the free scan.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl
	import bba_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [TDATA_W-1:0] m_tdata,
	output bba_ram_req_t            ram_req,
	input  wire logic [WORD_W-1:0]  ram_rdata
);

	bba_state_t         state_q, state_d;
	bba_action_t        action_q;
	logic [BLOCK_W-1:0] block_q;
	logic [WADDR_W-1:0] word_addr_q;
	logic [STORE_WORDS-1:0] valid_q;
	bba_res_t           res_q, res_d, m_res_q;
	logic               m_tvalid_q;

	bba_action_t        in_action;
	logic [BLOCK_W-1:0] in_block;
	logic               accept;
	logic               out_free;
	logic [WORD_W-1:0]  cur_word;
	logic [WORD_W-1:0]  scan_word;
	logic [WORD_W-1:0]  mod_word;
	logic               in_map;
	logic               last_word;
	logic               hit;
	logic [4:0]         hit_pos;
	logic               advance;

	assign in_action = bba_action_t'(s_tdata[1:0]);
	assign in_block  = s_tdata[2 +: BLOCK_W];
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	// words never written read as all free
	assign cur_word  = valid_q[word_addr_q] ? ram_rdata : '0;
	assign in_map    = {1'b0, block_q[BLOCK_W-1:3]} < MAPCMP_W'(MAP_BYTES);
	assign last_word = word_addr_q == WADDR_W'(MAP_WORDS - 1);

	// bytes past the end of the map count as full
	always_comb begin
		for (int b = 0; b < BYTES_PER_WORD; b++) begin
			if ({1'b0, word_addr_q, 2'(b)} < MAPCMP_W'(MAP_BYTES)) begin
				scan_word[8*b +: 8] = cur_word[8*b +: 8];
			end else begin
				scan_word[8*b +: 8] = 8'hFF;
			end
		end
	end

	// lowest clear bit of the word is the lowest clear bit of the first non-full byte
	always_comb begin
		hit     = 1'b0;
		hit_pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!scan_word[i]) begin
				hit     = 1'b1;
				hit_pos = 5'(i);
			end
		end
	end

	always_comb begin
		mod_word = cur_word;
		mod_word[block_q[4:0]] = (action_q == ACT_ASSIGN);
	end

	assign advance = (state_q == ST_SCAN) && !hit && !last_word;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (in_action == ACT_FIND) ? ST_SCAN : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				if (hit || last_word) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_tready      = 1'b0;
		ram_req       = '0;
		ram_req.waddr = word_addr_q;
		ram_req.wdata = mod_word;
		res_d         = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready      = 1'b1;
				ram_req.re    = s_tvalid;
				ram_req.raddr = (in_action == ACT_FIND) ? '0 : in_block[BLOCK_W-1:5];
			end
			ST_READ: begin
				ram_req.we    = in_map &&
				                (action_q == ACT_ASSIGN || action_q == ACT_RELEASE);
				res_d.is_free = in_map && (action_q == ACT_TEST) && !cur_word[block_q[4:0]];
			end
			ST_SCAN: begin
				ram_req.re        = advance;
				ram_req.raddr     = word_addr_q + WADDR_W'(1);
				res_d.found       = hit;
				res_d.found_block = hit ? {word_addr_q, hit_pos} : '0;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_req.we) begin
				valid_q[word_addr_q] <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q    <= in_action;
			block_q     <= in_block;
			word_addr_q <= (in_action == ACT_FIND) ? '0 : in_block[BLOCK_W-1:5];
		end else if (advance) begin
			word_addr_q <= word_addr_q + WADDR_W'(1);
		end
		if (state_q == ST_READ || (state_q == ST_SCAN && state_d == ST_DONE)) begin
			res_q <= res_d;
		end
		if (state_q == ST_DONE && out_free) begin
			m_res_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(TDATA_W - $bits(bba_res_t))'(0), m_res_q};

endmodule

`default_nettype wire
